// File: rtl/gaze_dwell_button_trigger_core_macros.svh
// Assertion macros used by the gaze dwell button top level.
`ifndef GAZE_DWELL_BUTTON_TRIGGER_CORE_MACROS_SVH
`define GAZE_DWELL_BUTTON_TRIGGER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define GDBT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gdbt assertion failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define GDBT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gdbt assertion failed");

`endif

// File: rtl/gdbt_pkg.sv
// Types and constants shared by the gaze dwell button modules.
`timescale 1ns / 1ps

package gdbt_pkg;

    localparam int DWELL_BITS     = 16;
    localparam int FLASH_BITS     = 16;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 3;
    localparam int PROG_FRAC_BITS = 8;
    localparam int PROG_BITS      = 9;
    localparam int OUT_DATA_BITS  = 16;

    localparam logic [PROG_BITS-1:0]  PROG_FULL   = 9'd256;
    localparam logic [PROG_BITS-1:0]  PROG_ZERO   = 9'd0;
    localparam logic [DWELL_BITS-1:0] DWELL_RESET = 16'd1000;
    localparam logic [FLASH_BITS-1:0] FLASH_RESET = 16'd200;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_RECT_LEFT,
        CFG_RECT_TOP,
        CFG_RECT_WIDTH,
        CFG_RECT_HEIGHT,
        CFG_DWELL_TIME,
        CFG_FLASH_LENGTH,
        CFG_RETRIGGER
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_DECIDE,
        ST_DIVIDE,
        ST_DONE
    } gdbt_state_t;

endpackage

// File: rtl/gaze_dwell_button_trigger_core.sv
// Top level of the gaze dwell button: configuration, sequencer and result register.
`timescale 1ns / 1ps

// The block takes one time-stamped gaze point per request on the s_ side and returns exactly
// one result per request on the m_ side. Each point is tested against the configured
// rectangle; the first point inside after an exit starts the dwell clock, later inside points
// report progress as elapsed / dwell_time in Q1.8 (256 is complete), and reaching the dwell
// time fires triggered and opens a flash window of flash_length ms. With retrigger_enable set
// the dwell clock restarts at once, otherwise the button stays disarmed until the gaze
// leaves. A point that needs a progress value passes through the difference pass, the decide
// state, the divide state (the restoring divider produces one quotient bit per cycle, then
// the quotient is taken) and the done state that hands the result over. Points that need no
// division skip the divide state. s_tready stays low while a point is in work. A finished
// result waits in the output register; the next point is still accepted, but its result
// waits in the done state until the register is free. Configuration writes are always
// accepted and should be issued only while the block is idle.
module gaze_dwell_button_trigger_core
    import gdbt_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int TIME_BITS  = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          s_tvalid,
    output logic                          s_tready,
    // Fields from bit 0 up: gaze_x, gaze_y, now_ms, zero padding.
    input  logic [((2*COORD_BITS+TIME_BITS+7)/8)*8-1:0] s_tdata,

    output logic                          m_tvalid,
    input  logic                          m_tready,
    // Fields from bit 0 up: triggered, flashing, inside_res, progress, zero padding.
    output logic [OUT_DATA_BITS-1:0]      m_tdata,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data
);

    `include "gaze_dwell_button_trigger_core_macros.svh"

    localparam int X_LSB = 0;
    localparam int Y_LSB = COORD_BITS;
    localparam int T_LSB = 2 * COORD_BITS;

    // Configuration registers.
    logic [COORD_BITS-1:0] rect_left_reg;
    logic [COORD_BITS-1:0] rect_top_reg;
    logic [COORD_BITS-1:0] rect_width_reg;
    logic [COORD_BITS-1:0] rect_height_reg;
    logic [DWELL_BITS-1:0] dwell_time_reg;
    logic [FLASH_BITS-1:0] flash_length_reg;
    logic                  retrigger_reg;

    // Dwell state carried from one point to the next.
    logic                  active_reg;
    logic                  armed_reg;
    logic [TIME_BITS-1:0]  start_reg;
    logic                  flash_on_reg;
    logic [TIME_BITS-1:0]  flash_until_reg;
    logic [PROG_BITS-1:0]  progress_reg;

    // Working registers for the point in flight.
    logic [COORD_BITS-1:0] gx_reg;
    logic [COORD_BITS-1:0] gy_reg;
    logic [TIME_BITS-1:0]  now_reg;
    logic                  inside_reg;
    logic [TIME_BITS-1:0]  elapsed_reg;
    logic [TIME_BITS-1:0]  dold_reg;
    logic [TIME_BITS-1:0]  dfire_reg;
    logic [TIME_BITS-1:0]  fu_new_reg;
    logic                  fired_reg;

    // Result register.
    logic                  m_tvalid_reg;
    logic                  out_trig_reg;
    logic                  out_flash_reg;
    logic                  out_inside_reg;
    logic [PROG_BITS-1:0]  out_prog_reg;

    gdbt_state_t           state_reg;
    gdbt_state_t           state_next;

    logic                  in_rect;
    logic                  due;
    logic                  fired;
    logic                  need_div;
    logic                  flash_any;
    logic [TIME_BITS-1:0]  flash_diff;
    logic                  flash_close;
    logic                  out_free;
    logic                  accept;
    logic                  div_start;
    logic                  div_done;
    logic                  out_load;
    logic [PROG_FRAC_BITS-1:0] div_quo;

    // Configuration port: a write is taken in every cycle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rect_left_reg    <= '0;
            rect_top_reg     <= '0;
            rect_width_reg   <= '0;
            rect_height_reg  <= '0;
            dwell_time_reg   <= DWELL_RESET;
            flash_length_reg <= FLASH_RESET;
            retrigger_reg    <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_RECT_LEFT:    rect_left_reg    <= cfg_data[COORD_BITS-1:0];
                CFG_RECT_TOP:     rect_top_reg     <= cfg_data[COORD_BITS-1:0];
                CFG_RECT_WIDTH:   rect_width_reg   <= cfg_data[COORD_BITS-1:0];
                CFG_RECT_HEIGHT:  rect_height_reg  <= cfg_data[COORD_BITS-1:0];
                CFG_DWELL_TIME:   dwell_time_reg   <= cfg_data[DWELL_BITS-1:0];
                CFG_FLASH_LENGTH: flash_length_reg <= cfg_data[FLASH_BITS-1:0];
                CFG_RETRIGGER:    retrigger_reg    <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    gdbt_rect #(
        .COORD_BITS (COORD_BITS)
    ) u_rect (
        .x       (gx_reg),
        .y       (gy_reg),
        .left    (rect_left_reg),
        .top     (rect_top_reg),
        .width   (rect_width_reg),
        .height  (rect_height_reg),
        .in_rect (in_rect)
    );

    // The divider only runs when elapsed is below dwell_time, so elapsed fits the low bits.
    gdbt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (elapsed_reg[DWELL_BITS-1:0]),
        .divisor  (dwell_time_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Decision logic for the point in flight, valid in the decide state.
    assign due      = elapsed_reg >= TIME_BITS'(dwell_time_reg);
    assign fired    = inside_reg && active_reg && due;
    assign need_div = inside_reg && active_reg && !due;

    // The flash closes once now is strictly after flash_until in half-range order.
    assign flash_any   = flash_on_reg || fired;
    assign flash_diff  = fired ? dfire_reg : dold_reg;
    assign flash_close = (flash_diff != '0) && !flash_diff[TIME_BITS-1];

    assign out_free = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_DIFF;
            ST_DIFF:   state_next = ST_DECIDE;
            ST_DECIDE: state_next = need_div ? ST_DIVIDE : ST_DONE;
            ST_DIVIDE: if (div_done) state_next = ST_DONE;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE:   s_tready  = 1'b1;
            ST_DECIDE: div_start = need_div;
            ST_DONE:   out_load  = out_free;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Capture the point, then form the time differences in one pass.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            gx_reg  <= s_tdata[X_LSB +: COORD_BITS];
            gy_reg  <= s_tdata[Y_LSB +: COORD_BITS];
            now_reg <= s_tdata[T_LSB +: TIME_BITS];
        end
        if (state_reg == ST_DIFF)
        begin
            inside_reg  <= in_rect;
            elapsed_reg <= now_reg - start_reg;
            dold_reg    <= now_reg - flash_until_reg;
            dfire_reg   <= '0 - TIME_BITS'(flash_length_reg);
            fu_new_reg  <= now_reg + TIME_BITS'(flash_length_reg);
        end
        if (state_reg == ST_DECIDE)
            fired_reg <= fired;
    end

    // Dwell state update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= 1'b0;
            armed_reg       <= 1'b1;
            start_reg       <= '0;
            flash_on_reg    <= 1'b0;
            flash_until_reg <= '0;
            progress_reg    <= PROG_ZERO;
        end
        else if (state_reg == ST_DECIDE)
        begin
            flash_on_reg <= flash_any && !flash_close;
            if (!inside_reg)
            begin
                active_reg   <= 1'b0;
                armed_reg    <= 1'b1;
                progress_reg <= PROG_ZERO;
            end
            else if (!active_reg)
            begin
                // Entry only records the start time; progress keeps its value.
                if (armed_reg)
                begin
                    start_reg  <= now_reg;
                    active_reg <= 1'b1;
                    armed_reg  <= 1'b0;
                end
            end
            else if (fired)
            begin
                start_reg       <= now_reg;
                flash_until_reg <= fu_new_reg;
                active_reg      <= retrigger_reg;
                progress_reg    <= retrigger_reg ? PROG_FULL : PROG_ZERO;
            end
        end
        else if (div_done)
        begin
            progress_reg <= {1'b0, div_quo};
        end
    end

    // Result register: holds a finished result until the sink takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (out_load)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_trig_reg   <= fired_reg;
            out_flash_reg  <= flash_on_reg;
            out_inside_reg <= inside_reg;
            out_prog_reg   <= progress_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_DATA_BITS'({out_prog_reg, out_inside_reg, out_flash_reg, out_trig_reg});

    // A quotient may only arrive while the sequencer waits for it.
    `GDBT_ASSERT_IMPL(a_div_done_in_divide, div_done, state_reg == ST_DIVIDE)
    // An accepted request moves the sequencer straight into the difference pass.
    `GDBT_ASSERT_NEXT(a_accept_to_diff, accept, state_reg == ST_DIFF)
    // A fired result always comes from a point inside the rectangle.
    `GDBT_ASSERT_IMPL(a_trig_inside, m_tvalid && m_tdata[0], m_tdata[2])
    // Progress never goes beyond one whole dwell.
    `GDBT_ASSERT_IMPL(a_prog_range, m_tvalid, m_tdata[11:3] <= PROG_FULL)

endmodule

// File: rtl/gdbt_rect.sv
// Point-in-rectangle test for the gaze button.
`timescale 1ns / 1ps

module gdbt_rect #(
    parameter int COORD_BITS = 12
) (
    input  logic [COORD_BITS-1:0] x,
    input  logic [COORD_BITS-1:0] y,
    input  logic [COORD_BITS-1:0] left,
    input  logic [COORD_BITS-1:0] top,
    input  logic [COORD_BITS-1:0] width,
    input  logic [COORD_BITS-1:0] height,
    output logic                  in_rect
);

    logic [COORD_BITS:0] right_edge;
    logic [COORD_BITS:0] bottom_edge;
    logic                in_x;
    logic                in_y;

    // The far edges carry one extra bit so that they never wrap.
    assign right_edge  = {1'b0, left} + {1'b0, width};
    assign bottom_edge = {1'b0, top} + {1'b0, height};

    assign in_x    = (x >= left) && ({1'b0, x} < right_edge);
    assign in_y    = (y >= top) && ({1'b0, y} < bottom_edge);
    assign in_rect = in_x && in_y;

endmodule

// File: rtl/gdbt_div.sv
// Restoring divider that produces the eight fraction bits of dwell progress.
`timescale 1ns / 1ps

module gdbt_div
    import gdbt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [DWELL_BITS-1:0]     dividend,
    input  logic [DWELL_BITS-1:0]     divisor,
    output logic                      done,
    output logic [PROG_FRAC_BITS-1:0] quotient
);

    localparam int CNT_BITS = $clog2(PROG_FRAC_BITS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(PROG_FRAC_BITS - 1);

    logic [DWELL_BITS-1:0]     rem_reg;
    logic [DWELL_BITS-1:0]     rem_next;
    logic [PROG_FRAC_BITS-1:0] quo_reg;
    logic [CNT_BITS-1:0]       cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [DWELL_BITS:0]       shifted;
    logic                      fits;

    // The remainder always stays below the divisor, so doubling it fits in one extra bit.
    assign shifted  = {rem_reg, 1'b0};
    assign fits     = shifted >= {1'b0, divisor};
    assign rem_next = fits ? DWELL_BITS'(shifted - {1'b0, divisor})
                           : DWELL_BITS'(shifted);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[PROG_FRAC_BITS-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: bench/tb.sv
// Self-checking stream testbench for the gaze dwell button trigger core.
`timescale 1ns / 1ps

// Gaze points go in through a queue that the stimulus process fills. A clocked driver offers
// them in bursts, and a clocked monitor checks every result against a model of the dwell
// button kept in this module. Each accepted point updates the model's copy of the button
// state, and the expected result is queued in acceptance order. The model's settings change
// only when a configuration request completes. Those requests are issued only while nothing
// is in flight. The block gives exactly one result per point, so no extra settling time is
// needed between phases.
module tb
    import gdbt_pkg::*;
;

    localparam int COORD_W = 12;
    localparam int TIME_W  = 32;
    localparam int IN_BITS = ((2*COORD_W+TIME_W+7)/8)*8;
    localparam int COORD_MAX = (1 << COORD_W) - 1;
    // Length of each long receiver hold-off, in cycles.
    localparam int LONG_HOLD = 300;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int RANDOM_PHASES = 14;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [TIME_W-1:0]  t;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } gaze_point_t;

    typedef struct packed {
        logic                 triggered;
        logic                 flashing;
        logic                 inside_res;
        logic [PROG_BITS-1:0] progress;
    } dwell_result_t;

    typedef enum logic [1:0] {
        PACE_OPEN,
        PACE_COIN,
        PACE_SPARSE,
        PACE_PERIODIC
    } pace_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               s_tvalid = 1'b0;
    logic               s_tready;
    // Fields from bit 0 up: gaze_x, gaze_y, now_ms, zero padding.
    logic [IN_BITS-1:0] s_tdata = '0;

    logic               m_tvalid;
    logic               m_tready = 1'b0;
    // Fields from bit 0 up: triggered, flashing, inside_res, progress, zero padding.
    logic [OUT_DATA_BITS-1:0] m_tdata;

    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    gaze_dwell_button_trigger_core #(
        .COORD_BITS(COORD_W),
        .TIME_BITS (TIME_W)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Button settings as last written. The initial values are the reset values.
    logic [COORD_W-1:0]    btn_left = '0;
    logic [COORD_W-1:0]    btn_top = '0;
    logic [COORD_W-1:0]    btn_width = '0;
    logic [COORD_W-1:0]    btn_height = '0;
    logic [DWELL_BITS-1:0] dwell_ms = DWELL_RESET;
    logic [FLASH_BITS-1:0] flash_ms = FLASH_RESET;
    logic                  retrig_on = 1'b0;

    // Dwell state of the button after the last accepted point.
    logic                 timing_on = 1'b0;
    logic                 rearm_ready = 1'b1;
    logic [TIME_W-1:0]    dwell_t0 = '0;
    logic                 flash_open = 1'b0;
    logic [TIME_W-1:0]    flash_end_ms = '0;
    logic [PROG_BITS-1:0] prog_now = PROG_ZERO;

    gaze_point_t   gaze_backlog[$];
    dwell_result_t verdicts_due[$];
    int points_queued = 0;
    int points_sent = 0;
    int error_count = 0;
    int holds_asked = 0;

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Advance the button by one gaze point and return what the block must report for it.
    function automatic dwell_result_t dwell_outcome(gaze_point_t p);
        dwell_result_t r;
        logic [COORD_W:0]  x_end;
        logic [COORD_W:0]  y_end;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] behind;
        logic [TIME_W+PROG_FRAC_BITS-1:0] scaled;
        logic is_in;
        logic fired;
        // The span ends are one bit wider so that a rectangle never wraps.
        x_end = {1'b0, btn_left} + {1'b0, btn_width};
        y_end = {1'b0, btn_top} + {1'b0, btn_height};
        is_in = p.x >= btn_left && {1'b0, p.x} < x_end &&
                p.y >= btn_top && {1'b0, p.y} < y_end;
        fired = 1'b0;
        if (is_in)
        begin
            if (!timing_on)
            begin
                // An entry only starts the clock and leaves progress where it was.
                if (rearm_ready)
                begin
                    dwell_t0 = p.t;
                    timing_on = 1'b1;
                    rearm_ready = 1'b0;
                end
            end
            else
            begin
                elapsed = p.t - dwell_t0;
                // A zero dwell time always lands here, so no division by zero occurs.
                if (elapsed >= TIME_W'(dwell_ms))
                begin
                    fired = 1'b1;
                    prog_now = PROG_FULL;
                    dwell_t0 = p.t;
                    flash_open = 1'b1;
                    flash_end_ms = p.t + TIME_W'(flash_ms);
                    if (!retrig_on)
                    begin
                        timing_on = 1'b0;
                        prog_now = PROG_ZERO;
                    end
                end
                else
                begin
                    scaled = {{PROG_FRAC_BITS{1'b0}}, elapsed} << PROG_FRAC_BITS;
                    prog_now = PROG_BITS'(scaled / (TIME_W+PROG_FRAC_BITS)'(dwell_ms));
                end
            end
        end
        else
        begin
            timing_on = 1'b0;
            prog_now = PROG_ZERO;
            rearm_ready = 1'b1;
        end
        // The flash closes once now is strictly after its end in half-range order.
        if (flash_open)
        begin
            behind = p.t - flash_end_ms;
            if (behind != 0 && !behind[TIME_W-1])
                flash_open = 1'b0;
        end
        r.triggered = fired;
        r.flashing = flash_open;
        r.inside_res = is_in;
        r.progress = prog_now;
        return r;
    endfunction

    function automatic void queue_point(int x, int y, logic [TIME_W-1:0] t);
        gaze_point_t p;
        p.x = COORD_W'(x);
        p.y = COORD_W'(y);
        p.t = t;
        gaze_backlog.push_back(p);
        points_queued++;
    endfunction

    // A point inside the button, or anywhere when the button is empty. Packed as {y, x}.
    function automatic logic [2*COORD_W-1:0] spot_in_button();
        int x_hi;
        int y_hi;
        if (btn_width == 0 || btn_height == 0)
            return {COORD_W'($urandom_range(0, COORD_MAX)), COORD_W'($urandom_range(0, COORD_MAX))};
        x_hi = int'(btn_left) + int'(btn_width) - 1;
        y_hi = int'(btn_top) + int'(btn_height) - 1;
        if (x_hi > COORD_MAX)
            x_hi = COORD_MAX;
        if (y_hi > COORD_MAX)
            y_hi = COORD_MAX;
        return {COORD_W'($urandom_range(btn_top, y_hi)), COORD_W'($urandom_range(btn_left, x_hi))};
    endfunction

    // A point off one side of the button where the chosen side has room, else anywhere. Packed as {y, x}.
    function automatic logic [2*COORD_W-1:0] spot_off_button();
        int x;
        int y;
        int x_after;
        int y_after;
        x = $urandom_range(0, COORD_MAX);
        y = $urandom_range(0, COORD_MAX);
        x_after = int'(btn_left) + int'(btn_width);
        y_after = int'(btn_top) + int'(btn_height);
        if ($urandom_range(0, 1) && btn_left > 0)
            x = $urandom_range(0, int'(btn_left) - 1);
        else if (x_after <= COORD_MAX)
            x = $urandom_range(x_after, COORD_MAX);
        else if (btn_top > 0)
            y = $urandom_range(0, int'(btn_top) - 1);
        else if (y_after <= COORD_MAX)
            y = $urandom_range(y_after, COORD_MAX);
        return {COORD_W'(y), COORD_W'(x)};
    endfunction

    // One configuration request. The caller lowers cfg_valid after its last request.
    task automatic cfg_write(cfg_index_t r, int value);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data <= CFG_DATA_BITS'(value);
        do @(posedge clk);
        while (!cfg_ready);
        case (r)
            CFG_RECT_LEFT:    btn_left = COORD_W'(value);
            CFG_RECT_TOP:     btn_top = COORD_W'(value);
            CFG_RECT_WIDTH:   btn_width = COORD_W'(value);
            CFG_RECT_HEIGHT:  btn_height = COORD_W'(value);
            CFG_DWELL_TIME:   dwell_ms = DWELL_BITS'(value);
            CFG_FLASH_LENGTH: flash_ms = FLASH_BITS'(value);
            CFG_RETRIGGER:    retrig_on = value[0];
            default:          ;
        endcase
    endtask

    task automatic apply_settings(int left, int top, int wid, int hgt, int dwell, int flash,
                                  int retrig);
        cfg_write(CFG_RECT_LEFT, left);
        cfg_write(CFG_RECT_TOP, top);
        cfg_write(CFG_RECT_WIDTH, wid);
        cfg_write(CFG_RECT_HEIGHT, hgt);
        cfg_write(CFG_DWELL_TIME, dwell);
        cfg_write(CFG_FLASH_LENGTH, flash);
        cfg_write(CFG_RETRIGGER, retrig);
        cfg_valid <= 1'b0;
    endtask

    // Returns once every queued point has been accepted and every result has come back.
    task automatic wait_idle();
        do @(posedge clk);
        while (points_sent != points_queued || verdicts_due.size() != 0);
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Stimulus: a short directed part, then random phases, each with its own settings.
    initial
    begin
        logic [TIME_W-1:0] clock_ms;
        logic [TIME_W-1:0] entry_ms;
        logic [2*COORD_W-1:0] spot;
        int phase_items;
        int left;
        int top;
        int wid;
        int hgt;
        int dwell;
        int flash;

        wait (rst_n === 1'b1);
        @(posedge clk);

        // Reset settings leave the button empty, so nothing can be inside.
        queue_point(0, 0, 0);
        queue_point(COORD_MAX, COORD_MAX, 32'hFFFF_FFFF);
        queue_point(2048, 2048, 5);
        wait_idle();

        // Plain button without retrigger: edges of both spans, entry, progress, fire, the
        // disarmed stretch, exit through the bottom edge and the close of the flash.
        apply_settings(100, 200, 50, 40, 1000, 200, 0);
        queue_point(99, 220, 10);
        queue_point(100, 200, 20);
        queue_point(149, 239, 520);
        queue_point(120, 210, 1020);
        queue_point(120, 210, 1100);
        queue_point(120, 240, 1150);
        queue_point(120, 210, 1300);
        queue_point(120, 210, 2299);
        wait_idle();

        // Button at the far corner, zero dwell time, zero flash, retrigger, time wrapping.
        apply_settings(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 1);
        queue_point(COORD_MAX, COORD_MAX, 32'hFFFF_FFF0);
        queue_point(COORD_MAX, COORD_MAX, 32'hFFFF_FFF0);
        queue_point(COORD_MAX, COORD_MAX, 5);
        queue_point(COORD_MAX - 1, COORD_MAX, 6);
        wait_idle();

        // Widest button, longest dwell and flash, fire with retrigger.
        apply_settings(0, 0, COORD_MAX, COORD_MAX, 65535, 65535, 1);
        queue_point(0, 0, 0);
        queue_point(COORD_MAX - 1, COORD_MAX - 1, 32767);
        queue_point(0, 0, 65535);
        queue_point(10, 10, 65536);
        queue_point(COORD_MAX, 0, 100);

        clock_ms = $urandom();
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            // Each phase starts from an idle block, so the sender has waited for every result.
            wait_idle();
            case ($urandom_range(0, 5))
                0:
                begin
                    left = 0;
                    top = 0;
                    wid = COORD_MAX;
                    hgt = COORD_MAX;
                end
                1:
                begin
                    left = $urandom_range(0, COORD_MAX);
                    top = $urandom_range(0, COORD_MAX);
                    wid = $urandom_range(0, 1) ? 0 : $urandom_range(1, 500);
                    hgt = (wid != 0) ? 0 : $urandom_range(0, 500);
                end
                2:
                begin
                    left = $urandom_range(0, COORD_MAX);
                    top = $urandom_range(0, COORD_MAX);
                    wid = $urandom_range(0, COORD_MAX);
                    hgt = $urandom_range(0, COORD_MAX);
                end
                default:
                begin
                    left = $urandom_range(0, 3500);
                    top = $urandom_range(0, 3500);
                    wid = $urandom_range(20, 600);
                    hgt = $urandom_range(20, 600);
                end
            endcase
            case ($urandom_range(0, 5))
                0:       dwell = 0;
                1:       dwell = 1;
                2:       dwell = 65535;
                3:       dwell = $urandom_range(0, 65535);
                default: dwell = $urandom_range(50, 3000);
            endcase
            case ($urandom_range(0, 4))
                0:       flash = 0;
                1:       flash = 65535;
                2:       flash = $urandom_range(0, 65535);
                default: flash = $urandom_range(10, 2000);
            endcase
            apply_settings(left, top, wid, hgt, dwell, flash, $urandom_range(0, 1));

            // Now and then run the phase across the wrap of the millisecond counter.
            if ($urandom_range(0, 3) == 0)
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 200000);

            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    // A dwell episode: usually an exit first, then an entry and a run of
                    // inside points whose spacing is scaled to the dwell time.
                    if ($urandom_range(0, 4) != 0)
                    begin
                        clock_ms = clock_ms + $urandom_range(0, 50);
                        spot = spot_off_button();
                        queue_point(spot[COORD_W-1:0], spot[2*COORD_W-1:COORD_W], clock_ms);
                        phase_items++;
                    end
                    entry_ms = clock_ms + $urandom_range(0, 50);
                    clock_ms = entry_ms;
                    spot = spot_in_button();
                    queue_point(spot[COORD_W-1:0], spot[2*COORD_W-1:COORD_W], clock_ms);
                    phase_items++;
                    repeat ($urandom_range(1, 8))
                    begin
                        case ($urandom_range(0, 9))
                            0:       clock_ms = clock_ms + $urandom();
                            1, 2:    clock_ms = clock_ms + $urandom_range(0, 3);
                            // Land on the dwell time or one short of it, counted from entry.
                            3:       clock_ms = entry_ms + dwell_ms - $urandom_range(0, 1);
                            default: clock_ms = clock_ms + $urandom_range(0, dwell_ms / 2 + 2);
                        endcase
                        spot = spot_in_button();
                        queue_point(spot[COORD_W-1:0], spot[2*COORD_W-1:COORD_W], clock_ms);
                        phase_items++;
                    end
                end
                else
                begin
                    // Noise: any point, at a nearby time or at an arbitrary one.
                    if ($urandom_range(0, 1))
                        clock_ms = clock_ms + $urandom_range(0, 3000);
                    else
                        clock_ms = $urandom();
                    queue_point($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                                clock_ms);
                    phase_items++;
                end
            end

            // Stall the receiver for a long stretch while this phase's points are offered.
            if (ph == 3 || ph == 10)
                holds_asked++;
        end

        wait_idle();
        repeat (16) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Driver: offers backlog points in bursts of random length with random gaps between them.
    // A point stays on the bus until it is accepted, and the model advances at that edge.
    always @(posedge clk)
    begin
        gaze_point_t   offer_next;
        dwell_result_t verdict;
        int burst_left;
        int gap_left;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            burst_left = 1;
            gap_left = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                verdict = dwell_outcome(gaze_point_t'(s_tdata[2*COORD_W+TIME_W-1:0]));
                verdicts_due.push_back(verdict);
                points_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (gaze_backlog.size() > 0)
                begin
                    offer_next = gaze_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= IN_BITS'(offer_next);
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 30);
                        // About a quarter of the bursts run straight into the next one.
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                    end
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: m_tready follows a pacing mode that is chosen anew whenever its stretch runs out, and a
    // request from the stimulus process starts one long hold-off counted here.
    always @(posedge clk)
    begin
        pace_t pace_mode;
        int pace_left;
        int pace_period;
        int pace_tick;
        int hold_left;
        int holds_taken;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            pace_left = 0;
            pace_tick = 0;
            hold_left = 0;
            holds_taken = 0;
        end
        else
        begin
            if (holds_taken != holds_asked)
            begin
                holds_taken = holds_asked;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                if (pace_left <= 0)
                begin
                    pace_mode = pace_t'($urandom_range(0, 3));
                    pace_left = $urandom_range(10, 150);
                    pace_period = $urandom_range(2, 6);
                end
                pace_left--;
                pace_tick++;
                case (pace_mode)
                    PACE_OPEN:     m_tready <= 1'b1;
                    PACE_COIN:     m_tready <= 1'($urandom_range(0, 1));
                    PACE_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
                    PACE_PERIODIC: m_tready <= (pace_tick % pace_period == 0);
                    default:       m_tready <= 1'b1;
                endcase
            end
        end
    end

    // Monitor: every accepted result must match the oldest expectation, field by field.
    always @(posedge clk)
    begin
        dwell_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (verdicts_due.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: result with none expected, expected nothing, actual %h",
                             $time, m_tdata);
            end
            else
            begin
                want = verdicts_due.pop_front();
                check_field("triggered", int'(want.triggered), int'(m_tdata[0]));
                check_field("flashing", int'(want.flashing), int'(m_tdata[1]));
                check_field("inside_res", int'(want.inside_res), int'(m_tdata[2]));
                check_field("progress", int'(want.progress), int'(m_tdata[3 +: PROG_BITS]));
            end
        end
    end

    // Limit on the whole run.
    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
